/* sv/tql_pkg.sv */
// Shared types and constants of the two-queue linked pool.
package tql_pkg;

  localparam int POOL_ENTRIES_DEF = 64;
  localparam int REC_W            = 32;
  localparam int KIND_W           = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_REVERSE = 3'd3,
    KIND_APPEND  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_LINK,
    ST_POP_LINK,
    ST_PEEK_RD,
    ST_REV_HEAD,
    ST_REV_STEP
  } state_t;

endpackage

/* sv/tql_ram.sv */
// Simple dual-port memory: one write port, one read port with registered data.
module tql_ram #(
  parameter int DEPTH = tql_pkg::POOL_ENTRIES_DEF,
  parameter int WIDTH = tql_pkg::REC_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import tql_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/two_queue_linked_pool_unit.sv */
// Top level: two FIFO queues kept as linked lists in a shared entry pool.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  command   | start, busy        | kind, queue_sel, entry_value
//  result    | done (1-cycle)     | status, head_value, queue_count, queue_empty
//
// Push, pop and peek are accepted, then make one link/record memory access; append and
// every refused command finish in the accepting cycle; reverse walks the list, one
// link-memory step per entry.
// done pulses in the cycle after the last working cycle; busy is low again then.
// After reset a clearing pass chains every link-memory entry into the free list;
// busy stays high during it. The receiver cannot stall results.
module two_queue_linked_pool_unit #(
  parameter int POOL_ENTRIES = tql_pkg::POOL_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [tql_pkg::KIND_W-1:0]        kind,
  input  logic                              queue_sel,
  input  logic [tql_pkg::REC_W-1:0]         entry_value,
  output logic                              done,
  output logic                              status,
  output logic [tql_pkg::REC_W-1:0]         head_value,
  output logic [$clog2(POOL_ENTRIES+1)-1:0] queue_count,
  output logic                              queue_empty
);
  import tql_pkg::*;

  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

  state_t state, state_next;

  logic [IDX_W-1:0] head [2];
  logic [IDX_W-1:0] head_next [2];
  logic [IDX_W-1:0] tail [2];
  logic [IDX_W-1:0] tail_next [2];
  logic [CNT_W-1:0] qlen [2];
  logic [CNT_W-1:0] qlen_next [2];
  logic [IDX_W-1:0] free_head, free_head_next;
  logic [CNT_W-1:0] free_len, free_len_next;

  logic             op_q, op_q_next;
  logic [IDX_W-1:0] op_node, op_node_next;
  logic [IDX_W-1:0] prev, prev_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] step_cnt, step_cnt_next;
  logic [IDX_W-1:0] clr_idx, clr_idx_next;

  logic             rep_q;
  logic             emit, emit_status, emit_q;
  logic [REC_W-1:0] emit_value;

  logic             link_we;
  logic [IDX_W-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
  logic             rec_we;
  logic [IDX_W-1:0] rec_waddr, rec_raddr;
  logic [REC_W-1:0] rec_rdata;

  tql_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(IDX_W)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  tql_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(REC_W)) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (entry_value),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      head      <= '{default: '0};
      tail      <= '{default: '0};
      qlen      <= '{default: '0};
      free_head <= '0;
      free_len  <= CNT_W'(POOL_ENTRIES);
      clr_idx   <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      qlen      <= qlen_next;
      free_head <= free_head_next;
      free_len  <= free_len_next;
      clr_idx   <= clr_idx_next;
      done      <= emit;
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_q_next;
    op_node  <= op_node_next;
    prev     <= prev_next;
    cur      <= cur_next;
    step_cnt <= step_cnt_next;
    if (emit) begin
      status     <= emit_status;
      head_value <= emit_value;
      rep_q      <= emit_q;
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    qlen_next      = qlen;
    free_head_next = free_head;
    free_len_next  = free_len;
    op_q_next      = op_q;
    op_node_next   = op_node;
    prev_next      = prev;
    cur_next       = cur;
    step_cnt_next  = step_cnt;
    clr_idx_next   = clr_idx;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = '0;
    link_raddr     = '0;
    rec_we         = 1'b0;
    rec_waddr      = '0;
    rec_raddr      = '0;
    emit           = 1'b0;
    emit_status    = 1'b0;
    emit_value     = '0;
    emit_q         = op_q;

    unique case (state)
      ST_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_idx;
        if (clr_idx == IDX_W'(POOL_ENTRIES - 1)) begin
          link_wdata = '0;
          state_next = ST_IDLE;
        end else begin
          link_wdata   = IDX_W'(clr_idx + 1'b1);
          clr_idx_next = IDX_W'(clr_idx + 1'b1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_q_next = queue_sel;
          emit_q    = queue_sel;
          case (kind)
            KIND_PUSH: begin
              if (free_len == '0) begin
                emit        = 1'b1;
                emit_status = 1'b1;
              end else begin
                link_raddr   = free_head;
                rec_we       = 1'b1;
                rec_waddr    = free_head;
                op_node_next = free_head;
                state_next   = ST_PUSH_LINK;
              end
            end
            KIND_POP: begin
              if (qlen[queue_sel] == '0) begin
                emit        = 1'b1;
                emit_status = 1'b1;
              end else begin
                link_raddr   = head[queue_sel];
                rec_raddr    = head[queue_sel];
                op_node_next = head[queue_sel];
                state_next   = ST_POP_LINK;
              end
            end
            KIND_PEEK: begin
              if (qlen[queue_sel] == '0) begin
                emit        = 1'b1;
                emit_status = 1'b1;
              end else begin
                rec_raddr  = head[queue_sel];
                state_next = ST_PEEK_RD;
              end
            end
            KIND_REVERSE: begin
              if (qlen[queue_sel] < CNT_W'(2)) begin
                emit        = 1'b1;
                emit_status = 1'b1;
              end else begin
                link_raddr    = head[queue_sel];
                prev_next     = head[queue_sel];
                step_cnt_next = CNT_W'(1);
                state_next    = ST_REV_HEAD;
              end
            end
            KIND_APPEND: begin
              op_q_next = 1'b0;
              emit_q    = 1'b0;
              emit      = 1'b1;
              if (qlen[1] == '0) begin
                emit_status = 1'b1;
              end else begin
                if (qlen[0] == '0) begin
                  head_next[0] = head[1];
                end else begin
                  link_we    = 1'b1;
                  link_waddr = tail[0];
                  link_wdata = head[1];
                end
                tail_next[0] = tail[1];
                qlen_next[0] = CNT_W'(qlen[0] + qlen[1]);
                qlen_next[1] = '0;
                head_next[1] = '0;
                tail_next[1] = '0;
              end
            end
            default: begin
              emit        = 1'b1;
              emit_status = 1'b1;
            end
          endcase
        end
      end

      ST_PUSH_LINK: begin
        free_head_next = link_rdata;
        free_len_next  = CNT_W'(free_len - 1'b1);
        if (qlen[op_q] == '0) begin
          head_next[op_q] = op_node;
        end else begin
          link_we    = 1'b1;
          link_waddr = tail[op_q];
          link_wdata = op_node;
        end
        tail_next[op_q] = op_node;
        qlen_next[op_q] = CNT_W'(qlen[op_q] + 1'b1);
        emit            = 1'b1;
        state_next      = ST_IDLE;
      end

      ST_POP_LINK: begin
        qlen_next[op_q] = CNT_W'(qlen[op_q] - 1'b1);
        if (qlen[op_q] == CNT_W'(1)) begin
          head_next[op_q] = '0;
          tail_next[op_q] = '0;
        end else begin
          head_next[op_q] = link_rdata;
        end
        // return the entry to the front of the free list
        link_we        = 1'b1;
        link_waddr     = op_node;
        link_wdata     = free_head;
        free_head_next = op_node;
        free_len_next  = CNT_W'(free_len + 1'b1);
        emit           = 1'b1;
        emit_value     = rec_rdata;
        state_next     = ST_IDLE;
      end

      ST_PEEK_RD: begin
        emit       = 1'b1;
        emit_value = rec_rdata;
        state_next = ST_IDLE;
      end

      ST_REV_HEAD: begin
        cur_next   = link_rdata;
        link_raddr = link_rdata;
        state_next = ST_REV_STEP;
      end

      ST_REV_STEP: begin
        // flip one link while fetching the successor of the next entry
        link_we       = 1'b1;
        link_waddr    = cur;
        link_wdata    = prev;
        prev_next     = cur;
        cur_next      = link_rdata;
        link_raddr    = link_rdata;
        step_cnt_next = CNT_W'(step_cnt + 1'b1);
        if (step_cnt == CNT_W'(qlen[op_q] - 1'b1)) begin
          tail_next[op_q] = head[op_q];
          head_next[op_q] = cur;
          emit            = 1'b1;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state != ST_IDLE);
  assign queue_count = qlen[rep_q];
  assign queue_empty = (qlen[rep_q] == '0);

endmodule

/* test/two_queue_linked_pool_checker.sv */
// Checker for the two-queue linked pool: predicts each command's result and compares it.
`timescale 1ns / 100ps
module two_queue_linked_pool_checker #(
  parameter int POOL  = tql_pkg::POOL_ENTRIES_DEF,
  parameter int CNT_W = $clog2(POOL + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [tql_pkg::KIND_W-1:0] kind,
  input  logic                       queue_sel,
  input  logic [tql_pkg::REC_W-1:0]  entry_value,
  input  logic                       done,
  input  logic                       status,
  input  logic [tql_pkg::REC_W-1:0]  head_value,
  input  logic [CNT_W-1:0]           queue_count,
  input  logic                       queue_empty,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic                      status;
    logic [tql_pkg::REC_W-1:0] head;
    logic [CNT_W-1:0]          count;
    logic                      empty;
  } outcome_t;

  // Each queue is held in order, head at index 0.
  logic [tql_pkg::REC_W-1:0] entries [2][POOL];
  int                        depth [2];
  outcome_t                  pending_outcomes [$];
  int                        bad = 0;

  assign mismatches = bad;

  function automatic outcome_t predict_outcome(input logic [tql_pkg::KIND_W-1:0] k,
                                               input logic s,
                                               input logic [tql_pkg::REC_W-1:0] v);
    outcome_t                  r;
    int                        rq;
    int                        i;
    logic [tql_pkg::REC_W-1:0] tmp;
    r.status = 1'b1;
    r.head   = '0;
    rq       = int'(s);
    case (k)
      tql_pkg::KIND_PUSH: begin
        if (depth[0] + depth[1] < POOL) begin
          entries[s][depth[s]] = v;
          depth[s]++;
          r.status = 1'b0;
        end
      end
      tql_pkg::KIND_POP: begin
        if (depth[s] > 0) begin
          r.head = entries[s][0];
          for (i = 1; i < depth[s]; i++) entries[s][i-1] = entries[s][i];
          depth[s]--;
          r.status = 1'b0;
        end
      end
      tql_pkg::KIND_PEEK: begin
        if (depth[s] > 0) begin
          r.head   = entries[s][0];
          r.status = 1'b0;
        end
      end
      tql_pkg::KIND_REVERSE: begin
        if (depth[s] >= 2) begin
          for (i = 0; i < depth[s] / 2; i++) begin
            tmp                         = entries[s][i];
            entries[s][i]               = entries[s][depth[s]-1-i];
            entries[s][depth[s]-1-i]    = tmp;
          end
          r.status = 1'b0;
        end
      end
      tql_pkg::KIND_APPEND: begin
        // append always reports queue A
        rq = 0;
        if (depth[1] > 0) begin
          for (i = 0; i < depth[1]; i++) entries[0][depth[0]+i] = entries[1][i];
          depth[0] += depth[1];
          depth[1] = 0;
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(depth[rq]);
    r.empty = (depth[rq] == 0);
    return r;
  endfunction

  task automatic note_fault(input string why, input outcome_t want);
    if (bad < 10)
      $display("%0t: %s: expected status %0d head %h count %0d empty %0d,",
               $realtime, why, want.status, want.head, want.count, want.empty,
               " got status %0d head %h count %0d empty %0d",
               status, head_value, queue_count, queue_empty);
    bad++;
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      depth[0] = 0;
      depth[1] = 0;
      pending_outcomes.delete();
    end else begin
      // retire the oldest outcome before taking a new transaction
      if (done === 1'b1) begin
        if (pending_outcomes.size() == 0) begin
          want = '0;
          note_fault("result with no command outstanding", want);
        end else begin
          want = pending_outcomes.pop_front();
          if (status !== want.status || head_value !== want.head ||
              queue_count !== want.count || queue_empty !== want.empty)
            note_fault("result mismatch", want);
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        pending_outcomes.push_back(predict_outcome(kind, queue_sel, entry_value));
    end
    outstanding <= pending_outcomes.size();
  end

endmodule

/* test/two_queue_linked_pool_unit_tb.sv */
// Testbench top: drives commands into the two-queue linked pool and gives the verdict.
`timescale 1ns / 100ps
module two_queue_linked_pool_unit_tb;

  localparam int         POOL              = tql_pkg::POOL_ENTRIES_DEF;
  localparam int         CNT_W             = $clog2(POOL + 1);
  localparam int         RANDOM_ITEMS      = 775;
  localparam int         STALL_LIMIT       = 2000;
  localparam int         DRAIN_CYCLES      = 2 * POOL + 16;
  localparam logic       SEL_A             = 1'b0;
  localparam logic       SEL_B             = 1'b1;
  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       start       = 1'b0;
  logic [tql_pkg::KIND_W-1:0] kind        = tql_pkg::KIND_PUSH;
  logic                       queue_sel   = SEL_A;
  logic [tql_pkg::REC_W-1:0]  entry_value = '0;
  logic                       busy;
  logic                       done;
  logic                       status;
  logic [tql_pkg::REC_W-1:0]  head_value;
  logic [CNT_W-1:0]           queue_count;
  logic                       queue_empty;
  int                         mismatches;
  int                         outstanding;
  int                         quiet_cycles = 0;
  bit                         steady = 1'b0;

  always #6 clk = ~clk;

  two_queue_linked_pool_unit #(.POOL_ENTRIES(POOL)) dut (
    .clk, .rst, .start, .busy, .kind, .queue_sel, .entry_value,
    .done, .status, .head_value, .queue_count, .queue_empty
  );

  two_queue_linked_pool_checker #(.POOL(POOL), .CNT_W(CNT_W)) pool_checker (
    .clk, .rst, .start, .busy, .kind, .queue_sel, .entry_value,
    .done, .status, .head_value, .queue_count, .queue_empty,
    .mismatches, .outstanding
  );

  // Count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic issue(input logic [tql_pkg::KIND_W-1:0] k, input logic s,
                       input logic [tql_pkg::REC_W-1:0] v);
    int gap;
    kind        <= k;
    queue_sel   <= s;
    entry_value <= v;
    start       <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // transaction taken at this edge
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue_random(input bit filling, input logic favored);
    int                         roll;
    logic [tql_pkg::KIND_W-1:0] k;
    logic                       s;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 68)      k = tql_pkg::KIND_PUSH;
      else if (roll < 76) k = tql_pkg::KIND_POP;
      else if (roll < 84) k = tql_pkg::KIND_PEEK;
      else if (roll < 90) k = tql_pkg::KIND_REVERSE;
      else if (roll < 96) k = tql_pkg::KIND_APPEND;
      else                k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    end else begin
      if (roll < 12)      k = tql_pkg::KIND_PUSH;
      else if (roll < 62) k = tql_pkg::KIND_POP;
      else if (roll < 74) k = tql_pkg::KIND_PEEK;
      else if (roll < 84) k = tql_pkg::KIND_REVERSE;
      else if (roll < 92) k = tql_pkg::KIND_APPEND;
      else                k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    end
    // lean toward one queue so that long lists build up
    s = ($urandom_range(0, 3) == 0) ? !favored : favored;
    issue(k, s, $urandom());
  endtask

  initial begin : stimulus
    int   i;
    int   phase_left;
    bit   filling;
    logic favored;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // refusals on an empty pool
    issue(tql_pkg::KIND_PEEK,    SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_POP,     SEL_B, 32'hFFFF_FFFF);
    issue(tql_pkg::KIND_REVERSE, SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_APPEND,  SEL_B, 32'h0000_0000);
    issue(KIND_UNUSED_FIRST,     SEL_B, 32'h1234_5678);
    issue(KIND_UNUSED_LAST,      SEL_A, 32'hFFFF_FFFF);
    // single entry cannot be reversed
    issue(tql_pkg::KIND_PUSH,    SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_REVERSE, SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_PUSH,    SEL_A, 32'hFFFF_FFFF);
    issue(tql_pkg::KIND_PUSH,    SEL_A, 32'h8000_0001);
    issue(tql_pkg::KIND_PUSH,    SEL_B, 32'h7FFF_FFFE);
    issue(tql_pkg::KIND_PEEK,    SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_REVERSE, SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_PEEK,    SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_POP,     SEL_A, 32'h0000_0000);
    // append onto a non-empty A
    issue(tql_pkg::KIND_APPEND,  SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_PEEK,    SEL_B, 32'h0000_0000);
    issue(tql_pkg::KIND_REVERSE, SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_POP,     SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_POP,     SEL_A, 32'h0000_0000);
    issue(tql_pkg::KIND_POP,     SEL_A, 32'h0000_0000);
    // append onto an empty A: A takes B's list
    issue(tql_pkg::KIND_PUSH,    SEL_B, 32'h1234_5678);
    issue(tql_pkg::KIND_PUSH,    SEL_B, 32'h9ABC_DEF0);
    issue(tql_pkg::KIND_APPEND,  SEL_B, 32'h0000_0000);
    issue(tql_pkg::KIND_POP,     SEL_A, 32'h0000_0000);

    // alternate fill and drain phases so the pool reaches full and empty
    filling    = 1'b1;
    favored    = 1'($urandom_range(0, 1));
    phase_left = $urandom_range(90, 160);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        favored    = 1'($urandom_range(0, 1));
        steady     = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(90, 160);
      end
      phase_left--;
      issue_random(filling, favored);
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* two_queue_linked_pool_unit.f */
sv/tql_pkg.sv
sv/tql_ram.sv
sv/two_queue_linked_pool_unit.sv
test/two_queue_linked_pool_checker.sv
test/two_queue_linked_pool_unit_tb.sv
